// ===== hw/rtl/dcpid_pkg.sv =====
// Shared types and constants for the dual-channel PID controller.
`timescale 1ns / 1ps

package dcpid_pkg;

	// Field and register widths
	localparam int ERR_W     = 32;
	localparam int GAIN_W    = 16;
	localparam int SUM_W     = 48;
	localparam int ACC_W     = 48;
	localparam int DRIVE_W   = 32;
	localparam int CFG_IDX_W = 3;

	// Default channel count
	localparam int CHANNELS_DEF = 2;

	// Gain reset values, unsigned Q8.8
	localparam logic [GAIN_W-1:0] KP_RST = 16'd26;
	localparam logic [GAIN_W-1:0] KI_RST = 16'd77;
	localparam logic [GAIN_W-1:0] KD_RST = 16'd13;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KP_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KI_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KD_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KP_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KI_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KD_Y = 3'd5;

	// Control law select
	localparam logic FUNC_POS = 1'b0;
	localparam logic FUNC_INC = 1'b1;

	// Gain bank select
	localparam logic BANK_X = 1'b0;
	localparam logic BANK_Y = 1'b1;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gain_t;

	typedef struct packed {
		logic signed [ERR_W-1:0] last_err;
		logic signed [ERR_W-1:0] prev_err;
		logic signed [SUM_W-1:0] err_sum;
		logic signed [ACC_W-1:0] out_acc;
	} chan_state_t;

endpackage

// ===== hw/rtl/dcpid_gains.sv =====
// Gain register file with per-bank readout.
`timescale 1ns / 1ps

module dcpid_gains
	import dcpid_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [GAIN_W-1:0]    cfg_data,
	input  logic                 bank,
	output gain_t                gains
);

	gain_t gain_x_q;
	gain_t gain_y_q;

	// Write one gain register; drop writes to unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_x_q <= '{kp: KP_RST, ki: KI_RST, kd: KD_RST};
			gain_y_q <= '{kp: KP_RST, ki: KI_RST, kd: KD_RST};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KP_X: gain_x_q.kp <= cfg_data;
				REG_KI_X: gain_x_q.ki <= cfg_data;
				REG_KD_X: gain_x_q.kd <= cfg_data;
				REG_KP_Y: gain_y_q.kp <= cfg_data;
				REG_KI_Y: gain_y_q.ki <= cfg_data;
				REG_KD_Y: gain_y_q.kd <= cfg_data;
				default: ;
			endcase
		end
	end

	// Select the bank for the transaction at hand
	assign gains = (bank == BANK_Y) ? gain_y_q : gain_x_q;

endmodule

// ===== hw/rtl/dcpid_datapath.sv =====
// Single-pass PID arithmetic: shared multipliers, sum, saturation, output scaling.
`timescale 1ns / 1ps

module dcpid_datapath
	import dcpid_pkg::*;
(
	input  logic signed [ERR_W-1:0]   err,
	input  logic                      func,
	input  gain_t                     gains,
	input  chan_state_t               cur,
	output chan_state_t               nxt,
	output logic signed [DRIVE_W-1:0] drive
);

	localparam int TOT_W = 67;

	// Clamp a wide value to the signed 48-bit range
	function automatic logic signed [ACC_W-1:0] sat48(input logic signed [TOT_W-1:0] v);
		logic signed [TOT_W-1:0] hi;
		logic signed [TOT_W-1:0] lo;
		hi = 67'sh7FFF_FFFF_FFFF;
		lo = -67'sh8000_0000_0000;
		if (v > hi)
			return 48'sh7FFF_FFFF_FFFF;
		else if (v < lo)
			return 48'sh8000_0000_0000;
		else
			return v[ACC_W-1:0];
	endfunction

	// Divide a Q.8 value by 256 toward zero, then clamp to 32 bits
	function automatic logic signed [DRIVE_W-1:0] to_drive(input logic signed [TOT_W-1:0] v);
		logic signed [58:0] q;
		logic signed [58:0] rnd;
		rnd = (v[TOT_W-1] && (v[7:0] != 8'd0)) ? 59'sd1 : 59'sd0;
		q = 59'(v >>> 8) + rnd;
		if (q > 59'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (q < -59'sd2147483648)
			return 32'sh8000_0000;
		else
			return $signed(q[DRIVE_W-1:0]);
	endfunction

	logic signed [16:0] kp_s, ki_s, kd_s;
	logic signed [32:0] op_a;
	logic signed [47:0] op_b;
	logic signed [34:0] op_c;
	logic signed [49:0] prod_a;
	logic signed [64:0] prod_b;
	logic signed [51:0] prod_c;
	logic signed [TOT_W-1:0] acc_in;
	logic signed [TOT_W-1:0] total;
	logic signed [ACC_W-1:0] acc_new;
	logic signed [SUM_W:0]   sum_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [TOT_W-1:0] drive_src;

	assign kp_s = $signed({1'b0, gains.kp});
	assign ki_s = $signed({1'b0, gains.ki});
	assign kd_s = $signed({1'b0, gains.kd});

	// Route multiplier operands by control law
	always_comb begin
		case (func)
			FUNC_POS: begin
				op_a = 33'(err);
				op_b = cur.err_sum;
				op_c = 35'(err) - 35'(cur.last_err);
			end
			FUNC_INC: begin
				op_a = 33'(err) - 33'(cur.prev_err);
				op_b = 48'(err);
				op_c = 35'(err) - (35'(cur.prev_err) <<< 1) + 35'(cur.last_err);
			end
			default: begin
				op_a = '0;
				op_b = '0;
				op_c = '0;
			end
		endcase
	end

	// Three gain products
	assign prod_a = kp_s * op_a;
	assign prod_b = ki_s * op_b;
	assign prod_c = kd_s * op_c;

	// Sum terms; incremental law adds onto the stored output
	assign acc_in  = (func == FUNC_INC) ? 67'(cur.out_acc) : '0;
	assign total   = 67'(prod_a) + 67'(prod_b) + 67'(prod_c) + acc_in;
	assign acc_new = sat48(total);

	// Saturating error integration
	assign sum_ext = 49'(cur.err_sum) + 49'(err);
	assign sum_new = sat48(67'(sum_ext));

	// Positional output comes from the unclamped total
	assign drive_src = (func == FUNC_INC) ? 67'(acc_new) : total;
	assign drive     = to_drive(drive_src);

	// Next channel state
	always_comb begin
		nxt = cur;
		nxt.out_acc = acc_new;
		case (func)
			FUNC_POS: begin
				nxt.last_err = err;
				nxt.err_sum  = sum_new;
			end
			FUNC_INC: begin
				nxt.last_err = cur.prev_err;
				nxt.prev_err = err;
			end
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/dual_channel_pid_controller.sv =====
// Top level of the dual-channel PID controller: input stage, channel state, result register.
//
//  Channel  Direction  Handshake           Payload
//  in       sink       in_valid/in_stall   error_value, channel, func
//  out      source     out_valid/out_stall drive
//  cfg      sink       cfg_we              cfg_index, cfg_data
//
// One transaction per cycle sustained while out_stall is low. Drive is registered: the
// accepted input passes the input register, then the result register.
// Channel state is read and written in the same cycle as the arithmetic pass,
// so back-to-back transactions on one channel see the updated state.
// Reset clears all channel state and loads the default gains.
// Output stall holds the result register and, with both registers full, stalls the input.
`timescale 1ns / 1ps

module dual_channel_pid_controller
	import dcpid_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [ERR_W-1:0]   error_value,
	input  logic                      channel,
	input  logic                      func,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DRIVE_W-1:0] drive,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [GAIN_W-1:0]         cfg_data
);

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	logic                      valid_s1;
	logic signed [ERR_W-1:0]   error_s1;
	logic                      channel_s1;
	logic                      func_s1;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	chan_state_t [CHANNELS-1:0] state_q;

	logic                      out_free;
	logic                      adv;
	logic                      accept;
	logic [CH_W-1:0]           ch_idx;
	chan_state_t               cur_state;
	chan_state_t               nxt_state;
	gain_t                     gains;
	logic signed [DRIVE_W-1:0] drive_c;

	// Handshake: advance when the result register is empty or being emptied
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			error_s1   <= error_value;
			channel_s1 <= channel;
			func_s1    <= func;
		end
	end

	// Clamp the channel onto the state that exists
	assign ch_idx    = (CH_W'(channel_s1) > LAST_CH) ? LAST_CH : CH_W'(channel_s1);
	assign cur_state = state_q[ch_idx];

	dcpid_gains u_gains (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bank      (channel_s1),
		.gains     (gains)
	);

	dcpid_datapath u_datapath (
		.err   (error_s1),
		.func  (func_s1),
		.gains (gains),
		.cur   (cur_state),
		.nxt   (nxt_state),
		.drive (drive_c)
	);

	// Update channel state as the transaction leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= '0;
		else if (adv)
			state_q[ch_idx] <= nxt_state;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv)
			drive_q <= drive_c;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// A transaction leaving the input stage shows up as a result next cycle
	a_adv_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced transaction did not reach the result register");

	// A new result only follows a transaction in the input stage
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a transaction");

	// Channel state holds while nothing advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("channel state changed without a transaction");

	// Positional law records the error as last error
	a_pos_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (func_s1 == FUNC_POS)) |=>
		(state_q[$past(ch_idx)].last_err == $past(error_s1)))
		else $error("positional step did not store the error");

	// Incremental law leaves the error sum alone
	a_inc_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (func_s1 == FUNC_INC)) |=>
		(state_q[$past(ch_idx)].err_sum == $past(cur_state.err_sum)))
		else $error("incremental step disturbed the error sum");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the dual-channel PID controller.
`timescale 1ns / 1ps

module tb;
	import dcpid_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 4;
	localparam int SOAK_PAIRS = 8;
	localparam int DIR_N = 18;

	localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFFFFFF;
	localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh80000000;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
	localparam logic [GAIN_W-1:0] GAIN_ZERO = 16'h0000;

	// Indexes past the last gain register; the block ignores them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [ERR_W-1:0] e;
		logic ch;
		logic fn;
		bit typed;
		logic signed [DRIVE_W-1:0] want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [ERR_W-1:0] error_value;
	logic channel;
	logic func;
	logic out_valid;
	logic out_stall;
	logic signed [DRIVE_W-1:0] drive;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0] cfg_data;

	// Predictor copy of gains and per-channel state
	logic [GAIN_W-1:0] g_kp [CHANNELS_DEF];
	logic [GAIN_W-1:0] g_ki [CHANNELS_DEF];
	logic [GAIN_W-1:0] g_kd [CHANNELS_DEF];
	logic signed [ERR_W-1:0] st_last [CHANNELS_DEF];
	logic signed [ERR_W-1:0] st_prev [CHANNELS_DEF];
	logic signed [SUM_W-1:0] st_sum [CHANNELS_DEF];
	logic signed [ACC_W-1:0] st_acc [CHANNELS_DEF];

	logic signed [DRIVE_W-1:0] drive_q [$];
	dir_row_t dir_rows [DIR_N];

	bit use_typed;
	logic signed [DRIVE_W-1:0] typed_drive;
	bit quiet_tx;
	bit quiet_rx;
	bit hold_req;
	int hold_left;
	int rx_left;
	int mismatches;
	int cycles;

	dual_channel_pid_controller dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.error_value (error_value),
		.channel     (channel),
		.func        (func),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive       (drive),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Clamp a wide signed value to the signed range of the given width
	function automatic logic signed [65:0] clamp_bits(input logic signed [65:0] v,
			input int bits);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = (66'sd1 <<< (bits - 1)) - 66'sd1;
		lo = -(66'sd1 <<< (bits - 1));
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Compute the drive for one error sample and advance the channel state.
	// The channel field is one bit, so it never exceeds the channel count.
	function automatic logic signed [DRIVE_W-1:0] next_drive(
			input logic signed [ERR_W-1:0] e, input logic ch, input logic fn);
		logic signed [65:0] ev;
		logic signed [65:0] pw;
		logic signed [65:0] iw;
		logic signed [65:0] dw;
		logic signed [65:0] lastw;
		logic signed [65:0] prevw;
		logic signed [65:0] sumw;
		logic signed [65:0] accw;
		logic signed [65:0] total;
		logic signed [65:0] delta;
		logic signed [65:0] q;
		ev = 66'(e);
		pw = 66'(g_kp[ch]);
		iw = 66'(g_ki[ch]);
		dw = 66'(g_kd[ch]);
		lastw = 66'(st_last[ch]);
		prevw = 66'(st_prev[ch]);
		sumw = 66'(st_sum[ch]);
		accw = 66'(st_acc[ch]);
		if (fn == FUNC_POS) begin
			// Sum holds earlier errors only; drive uses the 64-bit total
			total = pw * ev;
			total = clamp_bits(total + iw * sumw, 64);
			total = clamp_bits(total + dw * (ev - lastw), 64);
			st_acc[ch] = ACC_W'(clamp_bits(total, ACC_W));
			st_last[ch] = e;
			st_sum[ch] = SUM_W'(clamp_bits(sumw + ev, SUM_W));
			q = total;
		end else begin
			// Older error is the last-error register; shift prev into it
			delta = pw * (ev - prevw) + iw * ev + dw * (ev - (prevw <<< 1) + lastw);
			q = clamp_bits(accw + delta, ACC_W);
			st_acc[ch] = ACC_W'(q);
			st_last[ch] = st_prev[ch];
			st_prev[ch] = e;
		end
		q = q / 66'sd256;
		return DRIVE_W'(clamp_bits(q, DRIVE_W));
	endfunction

	function automatic logic signed [ERR_W-1:0] draw_err();
		logic signed [ERR_W-1:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: v = $urandom;
			4, 5, 6: v = $signed($urandom_range(0, 8192)) - 4096;
			7: v = ERR_MAX;
			8: v = ERR_MIN;
			default: v = $signed($urandom_range(0, 2)) - 1;
		endcase
		return v;
	endfunction

	// Offer one sample after a drawn gap and wait for its acceptance
	task automatic send_err(input logic signed [ERR_W-1:0] e, input logic ch,
			input logic fn, input bit typed, input logic signed [DRIVE_W-1:0] want);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		error_value <= e;
		channel <= ch;
		func <= fn;
		use_typed = typed;
		typed_drive = want;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering, wait for all expected drives, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_KP_X: g_kp[BANK_X] = val;
			REG_KI_X: g_ki[BANK_X] = val;
			REG_KD_X: g_kd[BANK_X] = val;
			REG_KP_Y: g_kp[BANK_Y] = val;
			REG_KI_Y: g_ki[BANK_Y] = val;
			REG_KD_Y: g_kd[BANK_Y] = val;
			default: ;
		endcase
	endtask

	task automatic set_gains(input logic [GAIN_W-1:0] kx, input logic [GAIN_W-1:0] ix,
			input logic [GAIN_W-1:0] dx, input logic [GAIN_W-1:0] ky,
			input logic [GAIN_W-1:0] iy, input logic [GAIN_W-1:0] dy);
		drain();
		write_reg(REG_KP_X, kx);
		write_reg(REG_KI_X, ix);
		write_reg(REG_KD_X, dx);
		write_reg(REG_KP_Y, ky);
		write_reg(REG_KI_Y, iy);
		write_reg(REG_KD_Y, dy);
	endtask

	// Random samples; switch idling on and off in chunks, hold the receiver once if asked
	task automatic run_random(input int n, input int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				quiet_tx = ($urandom_range(0, 3) == 0);
				quiet_rx = ($urandom_range(0, 3) == 0);
			end
			if (i == hold_at)
				hold_req = 1'b1;
			send_err(draw_err(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				1'b0, '0);
		end
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
	endtask

	// Cycle limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d drives still expected", $time, drive_q.size());
			$display("Verification failed");
			$finish;
		end
	end

	// Predict on every accepted input transaction
	always @(posedge clk) begin
		logic signed [DRIVE_W-1:0] pred;
		if (arst_n && in_valid && !in_stall) begin
			pred = next_drive(error_value, channel, func);
			drive_q.push_back(use_typed ? typed_drive : pred);
		end
	end

	// Check every accepted output transaction against the oldest expectation
	always @(posedge clk) begin
		logic signed [DRIVE_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected drive, expected none, actual %0d", $time, drive);
			end else begin
				want = drive_q.pop_front();
				if (drive !== want) begin
					mismatches++;
					$display("%0t: drive mismatch, expected %0d, actual %0d",
						$time, want, drive);
				end
			end
			rx_left = quiet_rx ? 0 : $urandom_range(0, 5);
		end
	end

	// Receiver stall: per-result wait, plus one long hold on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (rx_left > 0) begin
			out_stall <= 1'b1;
			rx_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		error_value = '0;
		channel = BANK_X;
		func = FUNC_POS;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KP_X;
		cfg_data = '0;
		use_typed = 1'b0;
		typed_drive = '0;
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		rx_left = 0;
		mismatches = 0;
		cycles = 0;
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			g_kp[c] = KP_RST;
			g_ki[c] = KI_RST;
			g_kd[c] = KD_RST;
			st_last[c] = '0;
			st_prev[c] = '0;
			st_sum[c] = '0;
			st_acc[c] = '0;
		end

		// Directed rows under reset gains; typed values follow from zero state
		dir_rows[0]  = '{32'sd0,    BANK_X, FUNC_POS, 1'b1, 32'sd0};
		dir_rows[1]  = '{32'sd256,  BANK_Y, FUNC_POS, 1'b1, 32'sd39};
		dir_rows[2]  = '{32'sd256,  BANK_X, FUNC_INC, 1'b1, 32'sd116};
		dir_rows[3]  = '{ERR_MAX,   BANK_X, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[4]  = '{ERR_MIN,   BANK_X, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[5]  = '{ERR_MAX,   BANK_Y, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[6]  = '{ERR_MIN,   BANK_Y, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[7]  = '{-32'sd1,   BANK_X, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[8]  = '{-32'sd1,   BANK_Y, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[9]  = '{32'sd1,    BANK_X, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[10] = '{-32'sd256, BANK_Y, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[11] = '{ERR_MAX,   BANK_X, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[12] = '{ERR_MAX,   BANK_X, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[13] = '{ERR_MIN,   BANK_X, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[14] = '{32'sd0,    BANK_Y, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[15] = '{32'sd0,    BANK_X, FUNC_POS, 1'b0, 32'sd0};
		dir_rows[16] = '{-32'sd100, BANK_Y, FUNC_INC, 1'b0, 32'sd0};
		dir_rows[17] = '{32'sd100,  BANK_Y, FUNC_POS, 1'b0, 32'sd0};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		for (int r = 0; r < DIR_N; r++)
			send_err(dir_rows[r].e, dir_rows[r].ch, dir_rows[r].fn, dir_rows[r].typed,
				dir_rows[r].want);
		drain();

		// Build large error sums, x high and y low, at full rate
		quiet_tx = 1'b1;
		quiet_rx = 1'b1;
		for (int k = 0; k < SOAK_PAIRS; k++) begin
			send_err(ERR_MAX, BANK_X, FUNC_POS, 1'b0, '0);
			send_err(ERR_MIN, BANK_Y, FUNC_POS, 1'b0, '0);
		end
		quiet_tx = 1'b0;
		quiet_rx = 1'b0;

		// Full gains on large sums: hit the 32-bit drive and 48-bit output limits
		set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		send_err(ERR_MIN, BANK_X, FUNC_POS, 1'b0, '0);
		send_err(ERR_MAX, BANK_X, FUNC_POS, 1'b0, '0);
		send_err(ERR_MAX, BANK_Y, FUNC_POS, 1'b0, '0);
		send_err(ERR_MIN, BANK_Y, FUNC_POS, 1'b0, '0);
		for (int k = 0; k < 3; k++) begin
			send_err(ERR_MAX, BANK_X, FUNC_INC, 1'b0, '0);
			send_err(ERR_MIN, BANK_Y, FUNC_INC, 1'b0, '0);
		end
		drain();

		// Spare indexes must leave the gains alone
		write_reg(REG_SPARE_6, 16'($urandom));
		write_reg(REG_SPARE_7, GAIN_ZERO);
		write_reg(REG_SPARE_7, GAIN_MAX);
		run_random(150, -1);

		set_gains(GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
		run_random(100, -1);

		set_gains(KP_RST, KI_RST, KD_RST, KP_RST, KI_RST, KD_RST);
		run_random(150, 60);

		for (int p = 0; p < 2; p++) begin
			set_gains(16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom));
			run_random(150, -1);
		end

		set_gains(GAIN_MAX, GAIN_ZERO, GAIN_MAX, GAIN_ZERO, GAIN_MAX, GAIN_ZERO);
		run_random(100, -1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && drive_q.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
